// File: sv/frp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants of the framed packet receiver
// Register indexes, parse phase codes, the configuration bundle and the
// result and status bundles passed between the receiver modules.
// ----------------------------------------------------------------------------
package frp_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_BYTE   = 2'd0;
    localparam logic [1:0] REG_ADDRESSES    = 2'd1;
    localparam logic [1:0] REG_COMMANDS     = 2'd2;
    localparam logic [1:0] REG_SIZE_MASK    = 2'd3;

    localparam logic [7:0] SIZE_MASK_RST    = 8'h07;

    // Parse phase codes
    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_ADDRESS  = 3'd1;
    localparam logic [2:0] PH_COMMAND  = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_CHECKSUM = 3'd4;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [31:0] accepted_addresses;
        logic [31:0] accepted_commands;
        logic [7:0]  size_mask;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  address;
        logic [7:0]  command;
        logic [7:0]  length;
        logic [63:0] payload;
    } result_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       escape_armed;
    } status_t;

    // True when the byte matches any of the four bytes packed in the set
    function automatic logic in_set(logic [31:0] set_word, logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (set_word[8*k +: 8] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

// File: sv/frp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_cfg_regs: configuration registers
// Holds frame byte, address set, command set and length mask; written
// through a plain write port with no read-back.
// ----------------------------------------------------------------------------
module frp_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output frp_pkg::cfg_t      cfg
);
    import frp_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_byte         <= 8'h00;
            cfg_reg.accepted_addresses <= 32'h0;
            cfg_reg.accepted_commands  <= 32'h0;
            cfg_reg.size_mask          <= SIZE_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_BYTE:  cfg_reg.frame_byte         <= cfg_data[7:0];
                REG_ADDRESSES:   cfg_reg.accepted_addresses <= cfg_data;
                REG_COMMANDS:    cfg_reg.accepted_commands  <= cfg_data;
                REG_SIZE_MASK:   cfg_reg.size_mask          <= cfg_data[7:0];
                default:         cfg_reg.size_mask          <= cfg_reg.size_mask;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: sv/frp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frp_parser: frame parser and payload store
// Walks one byte per accepted request through the start, address, command,
// data and checksum phases, undoes frame byte doubling, keeps the XOR
// checksum and flags a result when the checksum byte matches.
// ----------------------------------------------------------------------------
module frp_parser #(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire frp_pkg::cfg_t cfg,
    input  wire logic          in_fire,
    input  wire logic [7:0]    rx_byte,
    output logic               res_valid,
    output frp_pkg::result_t   res,
    output frp_pkg::status_t   status
);
    import frp_pkg::*;

    logic [2:0] phase_reg,   phase_next;
    logic       armed_reg,   armed_next;
    logic [7:0] address_reg, address_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg,  length_next;
    logic [7:0] count_reg,   count_next;
    logic [7:0] xor_reg,     xor_next;
    logic [7:0] store_reg [MAX_PAYLOAD];

    logic       store_we;
    logic       checksum_ok;
    logic [7:0] count_inc;
    logic [7:0] cmd_length;
    logic       is_frame;

    assign is_frame   = (rx_byte == cfg.frame_byte);
    assign count_inc  = count_reg + 8'd1;
    assign cmd_length = rx_byte & cfg.size_mask;

    // Next parse state for the byte at the input
    always_comb
    begin
        phase_next   = phase_reg;
        armed_next   = armed_reg;
        address_next = address_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        xor_next     = xor_reg;
        store_we     = 1'b0;
        checksum_ok  = 1'b0;
        case (phase_reg)
            PH_START:
            begin
                if (is_frame)
                begin
                    phase_next = PH_ADDRESS;
                end
            end
            PH_ADDRESS:
            begin
                if (in_set(cfg.accepted_addresses, rx_byte))
                begin
                    address_next = rx_byte;
                    phase_next   = PH_COMMAND;
                end
                else if (!is_frame)
                begin
                    phase_next = PH_START;
                end
            end
            PH_COMMAND:
            begin
                if (in_set(cfg.accepted_commands, rx_byte))
                begin
                    command_next = rx_byte;
                    xor_next     = rx_byte;
                    length_next  = cmd_length;
                    count_next   = 8'd0;
                    armed_next   = 1'b1;
                    phase_next   = (cmd_length == 8'd0) ? PH_CHECKSUM : PH_DATA;
                end
                else if (is_frame)
                begin
                    phase_next = PH_ADDRESS;
                end
                else
                begin
                    phase_next = PH_START;
                end
            end
            PH_DATA, PH_CHECKSUM:
            begin
                if (armed_reg && is_frame)
                begin
                    // first half of a doubled frame byte, or a lone one
                    armed_next = 1'b0;
                end
                else if (!armed_reg && !is_frame)
                begin
                    // lone frame byte: restart with this byte as address
                    address_next = rx_byte;
                    armed_next   = 1'b1;
                    phase_next   = PH_COMMAND;
                end
                else
                begin
                    armed_next = 1'b1;
                    if (phase_reg == PH_DATA)
                    begin
                        store_we   = 1'b1;
                        xor_next   = xor_reg ^ rx_byte;
                        count_next = count_inc;
                        if (count_inc >= length_reg)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                    end
                    else
                    begin
                        phase_next  = PH_START;
                        checksum_ok = (xor_reg == rx_byte);
                    end
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    // Advance parse state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            armed_reg   <= 1'b1;
            address_reg <= 8'h00;
            command_reg <= 8'h00;
            length_reg  <= 8'h00;
            count_reg   <= 8'h00;
            xor_reg     <= 8'h00;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            address_reg <= address_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            xor_reg     <= xor_next;
        end
    end

    // Store payload bytes while within the buffer; drop the rest
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PAYLOAD; k++)
        begin
            if (in_fire && store_we && (count_reg == 8'(k)))
            begin
                store_reg[k] <= rx_byte;
            end
        end
    end

    // Assemble the result; bytes at or beyond the length read as zero
    always_comb
    begin
        res.address = address_reg;
        res.command = command_reg;
        res.length  = length_reg;
        res.payload = 64'h0;
        for (int k = 0; k < MAX_PAYLOAD; k++)
        begin
            if (8'(k) < length_reg)
            begin
                res.payload[8*k +: 8] = store_reg[k];
            end
        end
    end

    assign res_valid           = in_fire && checksum_ok;
    assign status.phase        = phase_reg;
    assign status.escape_armed = armed_reg;

endmodule
`default_nettype wire

// File: sv/framed_packet_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// A packet appears on the result port in the cycle after its checksum byte is accepted.
// Throughput: one received byte per cycle; in_ready drops only while a finished
// packet waits in the result register and out_ready is low.
// Reset: asynchronous, active low; clears the parser to the start phase and
// the configuration registers to their defaults; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
// framed_packet_receiver: byte-stuffed frame parser with XOR checksum
// Parses address, command and payload from a byte stream and delivers each
// packet with a good checksum through a registered valid/ready result port.
// ----------------------------------------------------------------------------
module framed_packet_receiver #(
    parameter int MAX_PAYLOAD = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         packet_address,
    output logic [7:0]         packet_command,
    output logic [7:0]         payload_length,
    output logic [63:0]        payload
);
    import frp_pkg::*;

    cfg_t    cfg;
    result_t res;
    status_t status;
    logic    res_valid;
    logic    in_fire;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    frp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    // Take a request whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Hold a finished packet until it is taken
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign packet_address = out_reg.address;
    assign packet_command = out_reg.command;
    assign payload_length = out_reg.length;
    assign payload        = out_reg.payload;

`ifndef SYNTH
    // A result is produced only from a checksum byte actually taken in
    a_res_from_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (in_fire && status.phase == PH_CHECKSUM))
        else $error("result raised outside an accepted checksum byte");

    // Escape disarm only happens inside the data and checksum phases
    a_disarm_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !status.escape_armed |-> (status.phase == PH_DATA || status.phase == PH_CHECKSUM))
        else $error("escape disarmed outside payload phases");

    // Payload bytes at or beyond the length are zero
    a_payload_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && payload_length < 8'd8)
            |-> ((out_reg.payload >> {payload_length[2:0], 3'b000}) == 64'h0))
        else $error("payload bytes beyond length are not zero");
`endif

endmodule
`default_nettype wire

// File: bench/framed_packet_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_test: self-checking bench for the frame parser
// Streams framed byte sequences, both well formed and broken, through several
// register settings; both handshakes stall at random in all but the last mode.
// A scoreboard mirrors the parser and compares every delivered packet field by field.
// ----------------------------------------------------------------------------

// Mirror of the parser and store of packets still owed by the block
class frame_parse_scoreboard #(int DEPTH = 8);
    logic [7:0]  frame_byte;
    logic [31:0] addr_set;
    logic [31:0] cmd_set;
    logic [7:0]  len_mask;

    logic [2:0]  phase;
    bit          armed;
    logic [7:0]  addr_q;
    logic [7:0]  cmd_q;
    logic [7:0]  len_q;
    logic [7:0]  count_q;
    logic [7:0]  sum_q;
    logic [7:0]  store [DEPTH];

    frp_pkg::result_t awaited_packets[$];
    int errors;
    int bytes_seen;
    int packets_seen;

    function new();
        frame_byte   = 8'h00;
        addr_set     = '0;
        cmd_set      = '0;
        len_mask     = frp_pkg::SIZE_MASK_RST;
        phase        = frp_pkg::PH_START;
        armed        = 1'b1;
        addr_q       = '0;
        cmd_q        = '0;
        len_q        = '0;
        count_q      = '0;
        sum_q        = '0;
        foreach (store[i])
            store[i] = '0;
        errors       = 0;
        bytes_seen   = 0;
        packets_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] d);
        case (idx)
            frp_pkg::REG_FRAME_BYTE:  frame_byte = d[7:0];
            frp_pkg::REG_ADDRESSES:   addr_set   = d;
            frp_pkg::REG_COMMANDS:    cmd_set    = d;
            frp_pkg::REG_SIZE_MASK:   len_mask   = d[7:0];
            default: ;
        endcase
    endfunction

    function bit set_hit(logic [31:0] set_word, logic [7:0] b);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (set_word[8*k +: 8] == b)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Advance the mirrored parser by one accepted byte
    function void note_byte(logic [7:0] b);
        frp_pkg::result_t pkt;
        logic [63:0]      pl;
        bytes_seen++;
        case (phase)
            frp_pkg::PH_START:
            begin
                if (b == frame_byte)
                    phase = frp_pkg::PH_ADDRESS;
            end
            frp_pkg::PH_ADDRESS:
            begin
                if (set_hit(addr_set, b))
                begin
                    addr_q = b;
                    phase  = frp_pkg::PH_COMMAND;
                end
                else if (b != frame_byte)
                    phase = frp_pkg::PH_START;
            end
            frp_pkg::PH_COMMAND:
            begin
                if (set_hit(cmd_set, b))
                begin
                    cmd_q   = b;
                    sum_q   = b;
                    len_q   = b & len_mask;
                    count_q = '0;
                    armed   = 1'b1;
                    phase   = (len_q == 8'd0) ? frp_pkg::PH_CHECKSUM : frp_pkg::PH_DATA;
                end
                else if (b == frame_byte)
                    phase = frp_pkg::PH_ADDRESS;
                else
                    phase = frp_pkg::PH_START;
            end
            frp_pkg::PH_DATA, frp_pkg::PH_CHECKSUM:
            begin
                if (armed && b == frame_byte)
                    armed = 1'b0;
                else if (!armed && b != frame_byte)
                begin
                    // Lone frame byte: take this byte as an unchecked address
                    addr_q = b;
                    armed  = 1'b1;
                    phase  = frp_pkg::PH_COMMAND;
                end
                else if (phase == frp_pkg::PH_DATA)
                begin
                    armed = 1'b1;
                    if (count_q < DEPTH)
                        store[count_q] = b;
                    sum_q   = sum_q ^ b;
                    count_q = count_q + 8'd1;
                    if (count_q >= len_q)
                        phase = frp_pkg::PH_CHECKSUM;
                end
                else
                begin
                    armed = 1'b1;
                    phase = frp_pkg::PH_START;
                    if (sum_q == b)
                    begin
                        pl = '0;
                        for (int k = 0; k < DEPTH && k < 8; k++)
                        begin
                            if (k < len_q)
                                pl[8*k +: 8] = store[k];
                        end
                        pkt.address = addr_q;
                        pkt.command = cmd_q;
                        pkt.length  = len_q;
                        pkt.payload = pl;
                        awaited_packets.push_back(pkt);
                    end
                end
            end
            default: phase = frp_pkg::PH_START;
        endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare one delivered packet with the oldest one owed
    function void check_packet(logic [7:0] a, logic [7:0] c, logic [7:0] l, logic [63:0] p);
        frp_pkg::result_t want;
        if (awaited_packets.size() == 0)
        begin
            $display("%0t: packet with no match, expected none actual %h %h %h %h",
                     $time, a, c, l, p);
            errors++;
            return;
        end
        want = awaited_packets.pop_front();
        packets_seen++;
        compare_field("packet_address", {56'h0, want.address}, {56'h0, a});
        compare_field("packet_command", {56'h0, want.command}, {56'h0, c});
        compare_field("payload_length", {56'h0, want.length}, {56'h0, l});
        compare_field("payload", want.payload, p);
    endfunction
endclass

module framed_packet_receiver_test;
    import frp_pkg::*;

    localparam int STORE_DEPTH  = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_BYTES = 1400;

    // Fixed settings: frame byte, address set, command set, length mask
    localparam cfg_t DIRECTED_SETTING = {8'h7E, 32'hFF00_7E01, 32'h7E0F_080B, 8'h07};
    localparam cfg_t WIDE_SETTING     = {8'h00, 32'hFFFF_FFFF, 32'hC80C_0902, 8'hFF};
    localparam cfg_t NARROW_SETTING   = {8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  packet_address;
    logic [7:0]  packet_command;
    logic [7:0]  payload_length;
    logic [63:0] payload;

    int sender_gap_pct = 0;
    int reader_gap_pct = 0;
    int settings_used  = 0;
    int stall_cycles   = 0;

    frame_parse_scoreboard #(STORE_DEPTH) sb;

    framed_packet_receiver #(
        .MAX_PAYLOAD(STORE_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .packet_address(packet_address),
        .packet_command(packet_command),
        .payload_length(payload_length),
        .payload(payload)
    );

    always #5 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= reader_gap_pct);
    end

    // Check results mid-cycle, where valid and ready are settled
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_packet(packet_address, packet_command, payload_length, payload);
    end

    // Abort when no request moves on either side for too long
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
                $display("framed_packet_receiver test failed");
                $finish;
            end
        end
    end

    // Offer one byte and hold the request until it is taken
    task automatic send_byte(input logic [7:0] b);
        logic took;
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        sb.note_byte(b);
    endtask

    // Double a data byte that equals the frame byte
    task automatic send_stuffed(input logic [7:0] b);
        if (b == sb.frame_byte)
            send_byte(b);
        send_byte(b);
    endtask

    // Pause the sender until every owed packet has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (sb.awaited_packets.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.set_reg(idx, d);
    endtask

    task automatic apply_setting(input cfg_t s);
        hold_until_drained();
        write_reg(REG_FRAME_BYTE, {24'h0, s.frame_byte});
        write_reg(REG_ADDRESSES, s.accepted_addresses);
        write_reg(REG_COMMANDS, s.accepted_commands);
        write_reg(REG_SIZE_MASK, {24'h0, s.size_mask});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Send a complete frame with a given payload, first byte in the low byte
    task automatic send_fixed(input logic [7:0] a, input logic [7:0] c, input logic [63:0] data);
        logic [7:0] n;
        logic [7:0] sum;
        logic [7:0] d;
        n   = c & sb.len_mask;
        sum = c;
        send_byte(sb.frame_byte);
        send_byte(a);
        send_byte(c);
        for (int k = 0; k < n; k++)
        begin
            d   = data[8*k +: 8];
            sum = sum ^ d;
            send_stuffed(d);
        end
        send_stuffed(sum);
    endtask

    function automatic logic [7:0] pick_data();
        logic [7:0] d;
        d = 8'($urandom);
        if ($urandom_range(0, 5) == 0)
            d = sb.frame_byte;
        return d;
    endfunction

    function automatic logic [7:0] pick_address();
        int idx;
        idx = $urandom_range(0, 3);
        return sb.addr_set[8*idx +: 8];
    endfunction

    // Prefer short packets; long ones show up now and then
    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        int         idx;
        idx = $urandom_range(0, 3);
        c   = sb.cmd_set[8*idx +: 8];
        if ((c & sb.len_mask) > 8'd16 && $urandom_range(0, 7) != 0)
            c = sb.cmd_set[7:0];
        return c;
    endfunction

    // Send command, payload and checksum; cut_at stops early after that many bytes
    task automatic send_packet_body(input logic [7:0] c, input bit bad_sum, input int cut_at);
        logic [7:0] n;
        logic [7:0] sum;
        logic [7:0] d;
        n   = c & sb.len_mask;
        sum = c;
        send_byte(c);
        for (int k = 0; k < n; k++)
        begin
            if (k == cut_at)
                return;
            d   = pick_data();
            sum = sum ^ d;
            send_stuffed(d);
        end
        if (cut_at == n)
            return;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_stuffed(sum);
    endtask

    function automatic cfg_t random_setting(input bit overlap);
        cfg_t s;
        s.frame_byte         = 8'($urandom);
        s.accepted_addresses = $urandom;
        s.accepted_commands  = $urandom;
        case ($urandom_range(0, 3))
            0:       s.size_mask = 8'h07;
            1:       s.size_mask = 8'h0F;
            2:       s.size_mask = 8'h03;
            default: s.size_mask = 8'h0B;
        endcase
        // Put the frame byte into both sets so the set match must win
        if (overlap)
        begin
            s.accepted_addresses[23:16] = s.frame_byte;
            s.accepted_commands[15:8]   = s.frame_byte;
        end
        return s;
    endfunction

    // Mostly good frames; the rest are noise, bad checksums, restarts and cut frames
    task automatic send_random_frame();
        int         kind;
        int         cut;
        logic [7:0] a;
        logic [7:0] c;
        logic [7:0] x;
        kind = $urandom_range(0, 99);
        a    = pick_address();
        c    = pick_command();
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom));
            return;
        end
        send_byte(sb.frame_byte);
        if (kind < 18)
            send_byte(sb.frame_byte);
        else if (kind < 26)
        begin
            send_byte(a);
            send_byte(sb.frame_byte);
        end
        send_byte(a);
        if (kind < 80)
            send_packet_body(c, 1'b0, -1);
        else if (kind < 88)
            send_packet_body(c, 1'b1, -1);
        else if (kind < 95)
        begin
            // Drop a lone frame byte into the payload or checksum, then restart
            cut = ((c & sb.len_mask) == 8'd0) ? 0 : $urandom_range(0, (c & sb.len_mask) - 1);
            send_packet_body(c, 1'b0, cut);
            send_byte(sb.frame_byte);
            do
                x = 8'($urandom);
            while (x == sb.frame_byte);
            send_byte(x);
            send_packet_body(pick_command(), 1'b0, -1);
        end
        else
            send_packet_body(c, 1'b0, $urandom_range(0, c & sb.len_mask));
    endtask

    initial
    begin
        cfg_t setting;
        int   goal;
        sb = new();
        sender_gap_pct = 19;
        reader_gap_pct = 61;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a frame under reset values, then stuffing and set overlap
        send_fixed(8'h00, 8'h00, 64'h0);
        apply_setting(DIRECTED_SETTING);
        send_fixed(8'h01, 8'h0B, 64'h0000_0000_0022_7E11);
        send_fixed(8'h7E, 8'h7E, 64'h0000_5580_017E_FF00);

        // Random: three idling modes, two register settings each
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    sender_gap_pct = 19;
                    reader_gap_pct = 61;
                end
                1:
                begin
                    sender_gap_pct = 61;
                    reader_gap_pct = 19;
                end
                default:
                begin
                    sender_gap_pct = 0;
                    reader_gap_pct = 0;
                end
            endcase
            for (int part = 0; part < 2; part++)
            begin
                case (mode * 2 + part)
                    1:       setting = WIDE_SETTING;
                    3:       setting = NARROW_SETTING;
                    default: setting = random_setting(mode * 2 + part == 4);
                endcase
                apply_setting(setting);
                goal = sb.bytes_seen + RANDOM_BYTES / 6;
                while (sb.bytes_seen < goal)
                    send_random_frame();
            end
        end

        hold_until_drained();
        repeat (10) @(posedge clk);
        $display("Sent %0d bytes and checked %0d packets over %0d register settings,",
                 sb.bytes_seen, sb.packets_seen, settings_used);
        $display("with stuffing, restarts, bad checksums and overlong payloads; %0d errors.",
                 sb.errors);
        if (sb.errors == 0)
            $display("framed_packet_receiver test passed");
        else
            $display("framed_packet_receiver test failed");
        $finish;
    end
endmodule
